@@ rtl/core/fcgl_pkg.sv @@
package fcgl_pkg;

  localparam int SegDepth   = 256;
  localparam int GlyphDepth = 4096;
  localparam int KeyDepth   = 256;
  localparam int SegAw      = $clog2(SegDepth);
  localparam int GlyphAw    = $clog2(GlyphDepth);
  localparam int KeyAw      = $clog2(KeyDepth);
  localparam int SegCntW    = SegAw + 1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_SEG    = 2'd1;
  localparam logic [1:0] CMD_GLYPH  = 2'd2;
  localparam logic [1:0] CMD_KEY    = 2'd3;

  localparam logic [1:0] FMT_0 = 2'd0;
  localparam logic [1:0] FMT_2 = 2'd1;
  localparam logic [1:0] FMT_4 = 2'd2;
  localparam logic [1:0] FMT_6 = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_SEGCNT = 2'd1;
  localparam logic [1:0] REG_FIRST  = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] char_code;
    logic [11:0] entry_index;
    logic [15:0] end_or_first;
    logic [15:0] start_or_count;
    logic [15:0] delta_word;
    logic [15:0] offset_word;
    logic [15:0] table_word;
  } req_t;

  typedef struct packed {
    logic [15:0] glyph_id;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        table_format;
    logic [SegCntW-1:0] seg_count;
    logic [15:0]       first_code;
    logic [15:0]       entry_count;
  } cfg_t;

endpackage

@@ rtl/core/fcgl_ram.sv @@
module fcgl_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/fcgl_front.sv @@
module fcgl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fcgl_pkg::req_t req,
  output logic          busy,
  // queue entry toward the back part
  output logic          q_valid,
  output fcgl_pkg::req_t q_item,
  input  logic          q_take
);
  import fcgl_pkg::*;

  // two-entry queue; busy while full
  req_t       slot [2];
  logic [1:0] fill;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;

  assign busy    = fill[1];
  assign push    = start && !busy;
  assign q_valid = fill != 2'd0;
  assign q_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= req;
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_take) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_take};
    end
  end

  property p_no_take_empty;
    @(posedge clk) disable iff (rst) q_take |-> q_valid;
  endproperty
  a_no_take_empty: assert property (p_no_take_empty) else $error("take from empty queue");

  property p_no_overflow;
    @(posedge clk) disable iff (rst) fill != 2'd3;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_busy_full;
    @(posedge clk) disable iff (rst) push && !q_take && fill == 2'd1 |=> busy;
  endproperty
  a_busy_full: assert property (p_busy_full) else $error("busy not raised when full");
endmodule

@@ rtl/core/fcgl_back.sv @@
module fcgl_back (
  input  logic           clk,
  input  logic           rst,
  input  fcgl_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  fcgl_pkg::req_t q_item,
  output logic           q_take,
  output logic           done,
  output fcgl_pkg::rsp_t rsp
);
  import fcgl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KEY   = 7'b0000010,
    S_SEGRD = 7'b0000100,
    S_SEGCK = 7'b0001000,
    S_GLRD  = 7'b0010000,
    S_GLCK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t       state;
  req_t         cur;
  logic [SegAw-1:0]   idx;
  logic [SegCntW-1:0] seg_gap;
  logic [15:0]  delta;
  logic         use_delta;
  logic         byte_only;
  logic [15:0]  pos;
  rsp_t         res;

  // memories
  logic               seg_we, gl_we, key_we;
  logic [SegAw-1:0]   seg_ra;
  logic [GlyphAw-1:0] gl_ra;
  logic [KeyAw-1:0]   key_ra;
  logic [15:0] rd_end, rd_start, rd_delta, rd_range, rd_glyph;
  logic [7:0]  rd_key;

  assign seg_we = q_take && q_item.command == CMD_SEG &&
                  q_item.entry_index < 12'(SegDepth);
  assign gl_we  = q_take && q_item.command == CMD_GLYPH &&
                  {4'd0, q_item.entry_index} < 16'(GlyphDepth);
  assign key_we = q_take && q_item.command == CMD_KEY &&
                  q_item.entry_index < 12'(KeyDepth);

  // key read starts as the lookup leaves the queue
  assign key_ra = (state == S_IDLE) ? q_item.char_code[15:8] : cur.char_code[15:8];

  fcgl_ram #(.Width(16), .Depth(SegDepth)) u_end (.clk, .we(seg_we),
    .waddr(q_item.entry_index[SegAw-1:0]), .wdata(q_item.end_or_first),
    .raddr(seg_ra), .rdata(rd_end));
  fcgl_ram #(.Width(16), .Depth(SegDepth)) u_start (.clk, .we(seg_we),
    .waddr(q_item.entry_index[SegAw-1:0]), .wdata(q_item.start_or_count),
    .raddr(seg_ra), .rdata(rd_start));
  fcgl_ram #(.Width(16), .Depth(SegDepth)) u_delta (.clk, .we(seg_we),
    .waddr(q_item.entry_index[SegAw-1:0]), .wdata(q_item.delta_word),
    .raddr(seg_ra), .rdata(rd_delta));
  fcgl_ram #(.Width(16), .Depth(SegDepth)) u_range (.clk, .we(seg_we),
    .waddr(q_item.entry_index[SegAw-1:0]), .wdata(q_item.offset_word),
    .raddr(seg_ra), .rdata(rd_range));
  fcgl_ram #(.Width(16), .Depth(GlyphDepth)) u_glyph (.clk, .we(gl_we),
    .waddr(q_item.entry_index[GlyphAw-1:0]), .wdata(q_item.table_word),
    .raddr(gl_ra), .rdata(rd_glyph));
  fcgl_ram #(.Width(8), .Depth(KeyDepth)) u_key (.clk, .we(key_we),
    .waddr(q_item.entry_index[KeyAw-1:0]), .wdata(q_item.table_word[7:0]),
    .raddr(key_ra), .rdata(rd_key));

  assign q_take = q_valid && state == S_IDLE;
  assign gl_ra  = pos[GlyphAw-1:0];

  // segment read address: key result in format 2, walk index in format 4
  always_comb begin
    seg_ra = idx;
    if (state == S_KEY) seg_ra = rd_key[SegAw-1:0];
  end

  // combinational pieces of the segment check
  logic [15:0] cc;
  logic [16:0] lim;
  logic [15:0] j4;
  logic [15:0] lo;
  assign cc  = cur.char_code;
  assign lo  = {8'd0, cc[7:0]};
  assign lim = {1'b0, rd_end} + {1'b0, rd_start};
  assign j4  = rd_range - 16'({seg_gap, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur <= q_item;
            res <= '{glyph_id: 16'd0, status: ST_OK};
            use_delta <= 1'b0;
            byte_only <= 1'b0;
            delta <= 16'd0;
            if (q_item.command != CMD_LOOKUP) state <= S_OUT;
            else begin
              case (cfg.table_format)
                FMT_0: begin
                  if (q_item.char_code > 16'd255) begin
                    res.status <= ST_MISS; state <= S_OUT;
                  end else begin
                    pos <= q_item.char_code; byte_only <= 1'b1; state <= S_GLRD;
                  end
                end
                FMT_2: state <= S_KEY;
                FMT_4: begin
                  if (cfg.seg_count == '0) begin
                    res.status <= ST_MISS; state <= S_OUT;
                  end else begin
                    idx  <= SegAw'(((cfg.seg_count > SegCntW'(SegDepth)) ?
                            SegCntW'(SegDepth) : cfg.seg_count) - 1'b1);
                    seg_gap <= SegCntW'(1);
                    state <= S_SEGRD;
                  end
                end
                default: begin
                  pos <= q_item.char_code - cfg.first_code;
                  if ((q_item.char_code - cfg.first_code) >= cfg.entry_count) begin
                    res.status <= ST_MISS; state <= S_OUT;
                  end else state <= S_GLRD;
                end
              endcase
            end
          end
        end
        // key word is ready; the subheader read is addressed by it directly and idx keeps a copy
        S_KEY: begin
          idx <= rd_key[SegAw-1:0];
          if ({8'd0, rd_key} >= 16'(SegDepth)) begin
            res.status <= ST_MISS; state <= S_OUT;
          end else state <= S_SEGRD;
        end
        // wait for segment words
        S_SEGRD: state <= S_SEGCK;
        S_SEGCK: begin
          if (cfg.table_format == FMT_2) begin
            if (lo < rd_end || {1'b0, lo} >= lim) begin
              res.status <= ST_MISS; state <= S_OUT;
            end else begin
              pos <= {1'b0, rd_range[15:1]} + (lo - rd_end);
              delta <= rd_delta; use_delta <= 1'b1; state <= S_GLRD;
            end
          end else if (cc > rd_end) begin
            res.status <= ST_MISS; state <= S_OUT;
          end else if (cc >= rd_start) begin
            if (rd_range == 16'd0) begin
              res.glyph_id <= cc + rd_delta; state <= S_OUT;
            end else begin
              pos <= (cc - rd_start) + {1'b0, j4[15:1]};
              delta <= rd_delta; use_delta <= 1'b1; state <= S_GLRD;
            end
          end else if (idx == '0) begin
            res.status <= ST_MISS; state <= S_OUT;
          end else begin
            idx <= idx - 1'b1; seg_gap <= seg_gap + 1'b1; state <= S_SEGRD;
          end
        end
        S_GLRD: begin
          if (pos >= 16'(GlyphDepth)) begin
            res.status <= ST_RANGE; state <= S_OUT;
          end else state <= S_GLCK;
        end
        S_GLCK: begin
          if (byte_only) res.glyph_id <= {8'd0, rd_glyph[7:0]};
          else if (use_delta && rd_glyph != 16'd0) res.glyph_id <= rd_glyph + delta;
          else res.glyph_id <= rd_glyph;
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp = res;

  property p_done_idle;
    @(posedge clk) disable iff (rst) done |-> state == S_IDLE;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("done outside idle");

  property p_out_done;
    @(posedge clk) disable iff (rst) state == S_OUT |=> done;
  endproperty
  a_out_done: assert property (p_out_done) else $error("result lost");

  property p_status_code;
    @(posedge clk) disable iff (rst) done |-> rsp.status != 2'd3;
  endproperty
  a_status_code: assert property (p_status_code) else $error("bad status");
endmodule

@@ rtl/core/font_char_to_glyph_lookup_top.sv @@
// channel  | signals                             | transfer
// request  | start, busy, req                    | start && !busy
// result   | done, rsp                           | done (one cycle, no stall)
// config   | psel penable pwrite paddr pwdata    | psel && penable && pwrite
//
// a write command goes from the queue straight to the result; format 0 and 6
// lookups read and check the glyph store, format 2 lookups first read the key and
// the segment; format 4 walks the segments from the last one down, a read and a
// check for each, and then reads the glyph store when the segment needs it.
// reset is synchronous and clears control state and the registers; the tables
// hold nothing until written. a two-entry queue takes requests while the back
// works; busy rises when it is full. results cannot be held off.
module font_char_to_glyph_lookup_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  fcgl_pkg::req_t req,
  output logic           done,
  output fcgl_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fcgl_pkg::*;

  cfg_t cfg;
  logic q_valid, q_take;
  req_t q_item;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) cfg <= '0;
    else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (ridx)
        REG_FORMAT: cfg.table_format <= pwdata[1:0];
        REG_SEGCNT: cfg.seg_count    <= pwdata[SegCntW-1:0];
        REG_FIRST:  cfg.first_code   <= pwdata[15:0];
        REG_COUNT:  cfg.entry_count  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      REG_FORMAT: prdata = {30'd0, cfg.table_format};
      REG_SEGCNT: prdata = 32'(cfg.seg_count);
      REG_FIRST:  prdata = {16'd0, cfg.first_code};
      REG_COUNT:  prdata = {16'd0, cfg.entry_count};
      default:    prdata = 32'd0;
    endcase
  end

  fcgl_front u_front (.clk, .rst, .start, .req, .busy,
    .q_valid, .q_item, .q_take);

  fcgl_back u_back (.clk, .rst, .cfg, .q_valid, .q_item, .q_take, .done, .rsp);
endmodule
